/* hw/rtl/b24k_pkg.sv */
// Shared constants, types and the alphabet lookup for the base-24 key decoder.
package b24k_pkg;

  // Key framing
  localparam int SYMBOL_COUNT = 25;
  localparam int GROUP_LENGTH = 5;
  localparam int KEY_LENGTH   = SYMBOL_COUNT + (SYMBOL_COUNT - 1) / GROUP_LENGTH;
  localparam int POS_W        = $clog2(KEY_LENGTH);
  localparam int GRP_W        = $clog2(GROUP_LENGTH + 1);

  // Character and digit widths
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 5;
  localparam int RADIX   = 24;

  // Accumulator slicing into cells
  localparam int ACC_W     = 116;
  localparam int CELL_W    = 8;
  localparam int NUM_CELLS = (ACC_W + CELL_W - 1) / CELL_W;
  localparam int VEC_W     = NUM_CELLS * CELL_W;
  // Carry out of a cell stays below 27 for 8-bit slices, so 5 bits hold it
  localparam int CARRY_W   = 5;
  // Width of 24 * (slice + carry) + digit
  localparam int PROD_W    = CELL_W + 6;

  // Result fields
  localparam int LOW_W       = 31;
  localparam int HALF_W      = 42;
  localparam int UPPER_W     = 2 * HALF_W;
  localparam int OUT_FIELD_W = LOW_W + 2 * HALF_W;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  // Configuration
  localparam int                UB_W              = 4;
  localparam logic [UB_W-1:0]   UPPER_BYTES_RESET = 4'd11;

  // Per-transfer control broadcast to every cell
  typedef struct packed {
    logic step;   // a character is taken this cycle
    logic sym;    // character is a symbol, not a separator
    logic clr;    // start of key: drop the held value first
    logic flush;  // last character: cells return to zero afterwards
  } cell_ctrl_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] digit;
  } sym_t;

  // Alphabet BCDFGHJKMPQRTVWXY2346789 -> digit 0..23
  function automatic sym_t symbol_lookup(input logic [CHAR_W-1:0] ch);
    sym_t r;
    r.ok    = 1'b1;
    r.digit = '0;
    unique case (ch)
      8'h42: r.digit = 5'd0;   // B
      8'h43: r.digit = 5'd1;   // C
      8'h44: r.digit = 5'd2;   // D
      8'h46: r.digit = 5'd3;   // F
      8'h47: r.digit = 5'd4;   // G
      8'h48: r.digit = 5'd5;   // H
      8'h4A: r.digit = 5'd6;   // J
      8'h4B: r.digit = 5'd7;   // K
      8'h4D: r.digit = 5'd8;   // M
      8'h50: r.digit = 5'd9;   // P
      8'h51: r.digit = 5'd10;  // Q
      8'h52: r.digit = 5'd11;  // R
      8'h54: r.digit = 5'd12;  // T
      8'h56: r.digit = 5'd13;  // V
      8'h57: r.digit = 5'd14;  // W
      8'h58: r.digit = 5'd15;  // X
      8'h59: r.digit = 5'd16;  // Y
      8'h32: r.digit = 5'd17;  // 2
      8'h33: r.digit = 5'd18;  // 3
      8'h34: r.digit = 5'd19;  // 4
      8'h36: r.digit = 5'd20;  // 6
      8'h37: r.digit = 5'd21;  // 7
      8'h38: r.digit = 5'd22;  // 8
      8'h39: r.digit = 5'd23;  // 9
      default: r.ok = 1'b0;
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/b24k_cell.sv */
// One accumulator slice: on a symbol, slice' = 24 * (slice + carry from lower cell) + add_in.
module b24k_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  b24k_pkg::cell_ctrl_t           ctrl,
  input  logic [b24k_pkg::CARRY_W-1:0]   mul_in,   // registered carry of lower cell
  input  logic [b24k_pkg::CARRY_W-1:0]   add_in,   // digit for the lowest cell
  output logic [b24k_pkg::CELL_W-1:0]    s_nxt,
  output logic [b24k_pkg::CARRY_W-1:0]   c_nxt,
  output logic [b24k_pkg::CARRY_W-1:0]   c_q
);

  logic [b24k_pkg::CELL_W-1:0]  s_r;
  logic [b24k_pkg::CARRY_W-1:0] c_r;
  logic [b24k_pkg::CELL_W-1:0]  base_s;
  logic [b24k_pkg::CARRY_W-1:0] base_m;
  logic [b24k_pkg::CARRY_W-1:0] base_c;
  logic [b24k_pkg::CELL_W:0]    sum;
  logic [b24k_pkg::PROD_W-1:0]  sum_ext;
  logic [b24k_pkg::PROD_W-1:0]  t;

  // Times 24 as shift-add, then add the digit
  always_comb begin
    base_s  = ctrl.clr ? '0 : s_r;
    base_m  = ctrl.clr ? '0 : mul_in;
    base_c  = ctrl.clr ? '0 : c_r;
    sum     = {1'b0, base_s} + {{(b24k_pkg::CELL_W + 1 - b24k_pkg::CARRY_W){1'b0}}, base_m};
    sum_ext = {{(b24k_pkg::PROD_W - b24k_pkg::CELL_W - 1){1'b0}}, sum};
    t       = (sum_ext << 4) + (sum_ext << 3)
            + {{(b24k_pkg::PROD_W - b24k_pkg::CARRY_W){1'b0}}, add_in};
    if (ctrl.sym) begin
      s_nxt = t[b24k_pkg::CELL_W-1:0];
      c_nxt = t[b24k_pkg::CELL_W +: b24k_pkg::CARRY_W];
    end else begin
      s_nxt = base_s;
      c_nxt = base_c;
    end
  end

  // Slice and carry registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r <= '0;
      c_r <= '0;
    end else if (ctrl.step) begin
      s_r <= ctrl.flush ? '0 : s_nxt;
      c_r <= ctrl.flush ? '0 : c_nxt;
    end
  end

  assign c_q = c_r;

endmodule

/* hw/rtl/b24k_resolve.sv */
// Carry resolve, byte mask and output register for one decoded key.
module b24k_resolve (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load,      // last character taken
  input  logic [b24k_pkg::VEC_W-1:0]        s_vec,
  input  logic [b24k_pkg::VEC_W-1:0]        c_vec,
  input  logic                              err,
  input  logic [b24k_pkg::UB_W-1:0]         upper_bytes,
  output logic                              take_ok,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [b24k_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser
);

  logic                             a_valid_r;
  logic                             a_err_r;
  logic [b24k_pkg::VEC_W-1:0]       a_s_r;
  logic [b24k_pkg::VEC_W-1:0]       a_c_r;
  logic                             out_valid_r;
  logic [b24k_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic                             out_err_r;
  logic                             out_adv;
  logic [b24k_pkg::VEC_W-1:0]       value;
  logic [b24k_pkg::UPPER_W-1:0]     upper;
  logic [b24k_pkg::UPPER_W-1:0]     keep;
  logic [b24k_pkg::OUT_DATA_W-1:0]  data_nxt;

  // Stage handshake
  assign out_adv = !out_valid_r || out_tready;
  assign take_ok = !a_valid_r || out_adv;

  // Resolve the redundant form and mask the upper bytes
  always_comb begin
    value = a_s_r + a_c_r;
    upper = value[b24k_pkg::LOW_W +: b24k_pkg::UPPER_W];
    for (int k = 0; k < b24k_pkg::UPPER_W; k++) begin
      keep[k] = b24k_pkg::UB_W'(k >> 3) < upper_bytes;
    end
    data_nxt = '0;
    if (!a_err_r) begin
      data_nxt[b24k_pkg::OUT_FIELD_W-1:0] = {upper & keep, value[b24k_pkg::LOW_W-1:0]};
    end
  end

  // Snapshot stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (take_ok) begin
      a_valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (take_ok && load) begin
      a_s_r   <= s_vec;
      a_c_r   <= c_vec;
      a_err_r <= err;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && a_valid_r) begin
      out_data_r <= data_nxt;
      out_err_r  <= a_err_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_err_r;

endmodule

/* hw/rtl/base24_key_to_magnitude_unit.sv */
// Top level of the base-24 product key decoder.
//
// Usage:
//   in_*  : one key character per transfer. tdata = the raw character,
//           tuser = key start (clears position, value and error first).
//           29 characters make a key; positions 5, 11, 17 and 23 are
//           separators, taken but ignored.
//   out_* : one transfer per key. tdata = low 31 bits, then bits 31..72 and
//           73..114 after the upper-byte mask; tuser = bad-symbol flag
//           (all data zero when set).
//   cfg_* : cfg_we writes cfg_wdata as the number of upper bytes kept.
// Throughput: one character per cycle while in_tready is high. The value lives in a
// row of 8-bit cells, each multiplying its slice by 24 and passing a registered
// carry up one cell per character taken; the carries are merged by one wide add.
// The key's value is registered in the resolve stage and then in the output register.
// Reset clears the key state and sets upper bytes to 11. When the receiver
// stalls, one result waits in the output register and one more in the
// resolve stage; after that in_tready drops until the output drains.
module base24_key_to_magnitude_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [7:0] key_char
  input  logic                              in_tuser,   // [0] key_start
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [30:0] low_part, [72:31] upper_low_half, [114:73] upper_high_half, [119:115] zero
  output logic [b24k_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                              out_tuser,  // [0] key_error
  input  logic                              cfg_we,
  input  logic [b24k_pkg::UB_W-1:0]         cfg_wdata
);

  logic                          take;
  logic                          take_ok;
  logic [b24k_pkg::POS_W-1:0]    pos_r;
  logic [b24k_pkg::POS_W-1:0]    pos_eff;
  logic [b24k_pkg::GRP_W-1:0]    grp_r;
  logic [b24k_pkg::GRP_W-1:0]    grp_eff;
  logic                          err_r;
  logic                          err_nxt;
  logic                          sep;
  logic                          last;
  logic [b24k_pkg::UB_W-1:0]     ub_r;
  b24k_pkg::sym_t                lk;
  b24k_pkg::cell_ctrl_t          ctrl;
  logic [b24k_pkg::DIGIT_W-1:0]  digit;

  logic [b24k_pkg::CELL_W-1:0]   s_nxt [b24k_pkg::NUM_CELLS];
  logic [b24k_pkg::CARRY_W-1:0]  c_nxt [b24k_pkg::NUM_CELLS];
  logic [b24k_pkg::CARRY_W-1:0]  c_q   [b24k_pkg::NUM_CELLS];
  logic [b24k_pkg::VEC_W-1:0]    s_vec;
  logic [b24k_pkg::VEC_W-1:0]    c_vec;

  assign in_tready = take_ok;
  assign take      = in_tvalid && take_ok;

  // Position tracking and symbol decode
  always_comb begin
    pos_eff = in_tuser ? '0 : pos_r;
    grp_eff = in_tuser ? '0 : grp_r;
    sep     = grp_eff == b24k_pkg::GRP_W'(b24k_pkg::GROUP_LENGTH);
    last    = pos_eff == b24k_pkg::POS_W'(b24k_pkg::KEY_LENGTH - 1);
    lk      = b24k_pkg::symbol_lookup(in_tdata);
    digit   = lk.ok ? lk.digit : '0;
    err_nxt = (in_tuser ? 1'b0 : err_r) | (!sep && !lk.ok);
    ctrl.step  = take;
    ctrl.sym   = !sep;
    ctrl.clr   = in_tuser;
    ctrl.flush = last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      grp_r <= '0;
      err_r <= 1'b0;
    end else if (take) begin
      if (last) begin
        pos_r <= '0;
        grp_r <= '0;
        err_r <= 1'b0;
      end else begin
        pos_r <= pos_eff + 1'b1;
        grp_r <= sep ? '0 : grp_eff + 1'b1;
        err_r <= err_nxt;
      end
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ub_r <= b24k_pkg::UPPER_BYTES_RESET;
    end else if (cfg_we) begin
      ub_r <= cfg_wdata;
    end
  end

  // Row of accumulator cells, lowest slice first
  for (genvar i = 0; i < b24k_pkg::NUM_CELLS; i++) begin : g_cell
    if (i == 0) begin : g_low
      b24k_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .mul_in ('0),
        .add_in (digit),
        .s_nxt  (s_nxt[i]),
        .c_nxt  (c_nxt[i]),
        .c_q    (c_q[i])
      );
    end else begin : g_up
      b24k_cell u_cell (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .mul_in (c_q[i-1]),
        .add_in ('0),
        .s_nxt  (s_nxt[i]),
        .c_nxt  (c_nxt[i]),
        .c_q    (c_q[i])
      );
    end
  end

  // Gather slices and pending carries; the top carry falls off the word
  always_comb begin
    s_vec = '0;
    c_vec = '0;
    for (int i = 0; i < b24k_pkg::NUM_CELLS; i++) begin
      s_vec[i*b24k_pkg::CELL_W +: b24k_pkg::CELL_W] = s_nxt[i];
    end
    for (int i = 0; i < b24k_pkg::NUM_CELLS - 1; i++) begin
      c_vec[(i+1)*b24k_pkg::CELL_W +: b24k_pkg::CARRY_W] = c_nxt[i];
    end
  end

  b24k_resolve u_resolve (
    .clk         (clk),
    .rst_n       (rst_n),
    .load        (take && last),
    .s_vec       (s_vec),
    .c_vec       (c_vec),
    .err         (err_nxt),
    .upper_bytes (ub_r),
    .take_ok     (take_ok),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

endmodule
